### hdl/sst_pkg.sv
package sst_pkg;

    // table depth and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int KEY_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int COUNT_W  = 7;
    localparam int OUT_W    = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] F_SEARCH = 2'd0;
    localparam logic [FUNC_W-1:0] F_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] F_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] F_CLEAR  = 2'd3;

endpackage

### hdl/sorted_set_table_top.sv
// Clear goes straight to the result. Search, insert and remove run a binary search (probe
// read at mid, then narrow the window), then fetch the key at the lower bound to decide;
// insert and remove then shift the entries above it one place, pipelined through the memory.
// One transaction at a time: the next is accepted the cycle after the result is taken;
// the search loop and the one-read/one-write key memory set the pace.
// Reset (i_rst_n, synchronous, active low) empties the table and idles the sequencer.
module sorted_set_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] key (signed)
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] func
    // result side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [0] found, [1] changed, [2] full_refused,
                                          // [9:3] count, [15:10] zero
);

    localparam int CNT_W = sst_pkg::CNT_W;
    localparam int IDX_W = sst_pkg::IDX_W;
    localparam int KEY_W = sst_pkg::KEY_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
    localparam logic [2:0] S_SRCH  = 3'd1;  // issue probe read at mid, or at lo when done
    localparam logic [2:0] S_SWAIT = 3'd2;  // probe data back: narrow the window
    localparam logic [2:0] S_PCMP  = 3'd3;  // key at lower bound back: decide
    localparam logic [2:0] S_SHIFT = 3'd4;  // move entries one place, pipelined
    localparam logic [2:0] S_OUT   = 3'd5;  // result held until taken

    // key memory: single write port, single registered read port
    logic signed [KEY_W-1:0] r_mem [sst_pkg::CAPACITY];
    logic signed [KEY_W-1:0] r_rdata;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [IDX_W-1:0]        mem_raddr;
    logic signed [KEY_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // control and working registers
    logic [2:0]                     r_state,   n_state;
    logic [CNT_W-1:0]               r_cnt,     n_cnt;
    logic [CNT_W-1:0]               r_lo,      n_lo;
    logic [CNT_W-1:0]               r_hi,      n_hi;
    logic [CNT_W-1:0]               r_left,    n_left;    // reads still to issue
    logic [IDX_W-1:0]               r_rd,      n_rd;      // next read address of shift
    logic [IDX_W-1:0]               r_wa,      n_wa;      // write address of data in flight
    logic                           r_pend,    n_pend;    // read data due to be written
    logic [sst_pkg::FUNC_W-1:0]     r_func,    n_func;
    logic signed [KEY_W-1:0]        r_key,     n_key;
    logic                           r_found,   n_found;
    logic                           r_changed, n_changed;
    logic                           r_refused, n_refused;

    logic [CNT_W-1:0] mid;
    logic             present;
    logic             shift_up;

    // midpoint of the search window; hi never exceeds the count, so mid fits an index
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign present  = (r_lo < r_cnt) && (r_rdata == r_key);
    assign shift_up = (r_func == sst_pkg::F_INSERT);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_left    = r_left;
        n_rd      = r_rd;
        n_wa      = r_wa;
        n_pend    = r_pend;
        n_func    = r_func;
        n_key     = r_key;
        n_found   = r_found;
        n_changed = r_changed;
        n_refused = r_refused;
        mem_we    = 1'b0;
        mem_waddr = r_wa;
        mem_wdata = r_rdata;
        mem_raddr = r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_func    = i_s_axis_tuser;
                    n_key     = i_s_axis_tdata;
                    n_found   = 1'b0;
                    n_refused = 1'b0;
                    n_changed = 1'b0;
                    n_lo      = '0;
                    n_hi      = r_cnt;
                    if (i_s_axis_tuser == sst_pkg::F_CLEAR) begin
                        n_changed = (r_cnt != '0);
                        n_cnt     = '0;
                        n_state   = S_OUT;
                    end else begin
                        n_state   = S_SRCH;
                    end
                end
            end

            S_SRCH: begin
                if (r_lo < r_hi) begin
                    mem_raddr = mid[IDX_W-1:0];
                    n_state   = S_SWAIT;
                end else begin
                    // lower bound found; fetch it for the equality check
                    // (an out-of-range lo is masked by the compare)
                    mem_raddr = r_lo[IDX_W-1:0];
                    n_state   = S_PCMP;
                end
            end

            S_SWAIT: begin
                if (r_rdata < r_key) begin
                    n_lo = mid + CNT_W'(1);
                end else begin
                    n_hi = mid;
                end
                n_state = S_SRCH;
            end

            S_PCMP: begin
                n_found = present;
                n_pend  = 1'b0;
                n_state = S_OUT;
                case (r_func)
                    sst_pkg::F_INSERT: begin
                        if (!present) begin
                            if (r_cnt == CNT_W'(sst_pkg::CAPACITY)) begin
                                n_refused = 1'b1;
                            end else begin
                                // move [lo, cnt-1] up by one, highest first
                                n_left  = r_cnt - r_lo;
                                n_rd    = IDX_W'(r_cnt - CNT_W'(1));
                                n_state = S_SHIFT;
                            end
                        end
                    end
                    sst_pkg::F_REMOVE: begin
                        if (present) begin
                            // move [lo+1, cnt-1] down by one, lowest first
                            n_left  = r_cnt - r_lo - CNT_W'(1);
                            n_rd    = IDX_W'(r_lo + CNT_W'(1));
                            n_state = S_SHIFT;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_SHIFT: begin
                // write back what was read last cycle, read the next one
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wa;
                    mem_wdata = r_rdata;
                end
                if (r_left != '0) begin
                    mem_raddr = r_rd;
                    n_pend    = 1'b1;
                    n_left    = r_left - CNT_W'(1);
                    if (shift_up) begin
                        n_wa = r_rd + IDX_W'(1);
                        n_rd = r_rd - IDX_W'(1);
                    end else begin
                        n_wa = r_rd - IDX_W'(1);
                        n_rd = r_rd + IDX_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        // pipe drained: on insert, drop the new key into its slot
                        n_changed = 1'b1;
                        n_state   = S_OUT;
                        if (shift_up) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_lo[IDX_W-1:0];
                            mem_wdata = r_key;
                            n_cnt     = r_cnt + CNT_W'(1);
                        end else begin
                            n_cnt     = r_cnt - CNT_W'(1);
                        end
                    end
                end
            end

            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_left    <= n_left;
        r_rd      <= n_rd;
        r_wa      <= n_wa;
        r_func    <= n_func;
        r_key     <= n_key;
        r_found   <= n_found;
        r_changed <= n_changed;
        r_refused <= n_refused;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {6'd0, sst_pkg::COUNT_W'(r_cnt), r_refused, r_changed, r_found};

endmodule
